@@ hdl/tatc_pkg.sv @@
// ----------------------------------------------------------------------------
// tatc_pkg
// Shared widths, constants and types of the thermistor-to-temperature block.
// ----------------------------------------------------------------------------
package tatc_pkg;

  localparam int ADC_BITS_DEF = 12;

  localparam int S_W        = 12;
  localparam int SER_W      = 20;
  localparam int BETA_W     = 14;
  localparam int LRI_W      = 22;
  localparam int RES_W      = 32;
  localparam int K_W        = 17;
  localparam int C_W        = 18;
  localparam int F_W        = 19;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;

  localparam int FRAC_BITS  = 24;
  localparam int MANT_W     = 31;
  localparam int LN_LAT     = FRAC_BITS + 4;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  localparam logic [K_W-1:0] KELVIN_MAX   = 17'd100000;
  localparam int             ZERO_C_CENTI = 27315;
  localparam int             ZERO_F_CENTI = 45967;

  localparam int              DIV5_SH  = 23;
  localparam logic [20:0]     DIV5_MUL = 21'd1677722;

  localparam logic [S_W-1:0]          FULL_SCALE_RST = 12'd1023;
  localparam logic [SER_W-1:0]        SERIES_RST     = 20'd10000;
  localparam logic [BETA_W-1:0]       BETA_RST       = 14'd3950;
  localparam logic signed [LRI_W-1:0] LRI_RST        = -22'sd264700;
  localparam logic                    LOW_SIDE_RST   = 1'b1;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_SHORT = 2'd1,
    ST_SAT   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_SCALE = 3'd0,
    REG_SERIES     = 3'd1,
    REG_BETA       = 3'd2,
    REG_LOG_RINF   = 3'd3,
    REG_LOW_SIDE   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic short_f;
    logic full_f;
    logic nzero_f;
    logic dpos_f;
    logic ovf_f;
  } side_t;

endpackage

@@ hdl/tatc_if.sv @@
// ----------------------------------------------------------------------------
// tatc_if
// Valid/ready channels of the thermistor-to-temperature block.
// ----------------------------------------------------------------------------
interface tatc_in_if import tatc_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [S_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface tatc_out_if import tatc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [RES_W-1:0]      resistance_ohms;
  logic [K_W-1:0]        kelvin_centi;
  logic signed [C_W-1:0] celsius_centi;
  logic signed [F_W-1:0] fahrenheit_centi;
  logic [ST_W-1:0]       status;

  modport source (output valid, output resistance_ohms, output kelvin_centi,
                  output celsius_centi, output fahrenheit_centi, output status,
                  input ready);
  modport sink   (input valid, input resistance_ohms, input kelvin_centi,
                  input celsius_centi, input fahrenheit_centi, input status,
                  output ready);
endinterface

interface tatc_cfg_if import tatc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hdl/tatc_ln.sv @@
// ----------------------------------------------------------------------------
// tatc_ln
// Pipelined natural log in Q.24: leading one, normalize, 24 squaring stages,
// scale by ln 2. Advances on en.
// ----------------------------------------------------------------------------
module tatc_ln import tatc_pkg::*; #(
  parameter int XW = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [XW-1:0]                 x,
  output logic [$clog2(XW)+FRAC_BITS-1:0] ln_q
);

  localparam int EW  = $clog2(XW);
  localparam int L2W = EW + FRAC_BITS;
  localparam int PW  = L2W + 32;

  logic [XW-1:0]          x1_r;
  logic [EW-1:0]          e_lz;
  logic [EW-1:0]          e1_r;
  logic [XW+MANT_W-2:0]   shl;
  logic [MANT_W-1:0]      m_r [0:FRAC_BITS];
  logic [FRAC_BITS-1:0]   f_r [0:FRAC_BITS];
  logic [EW-1:0]          e_r [0:FRAC_BITS];
  logic [PW-1:0]          lp_r;
  logic [PW-1:0]          lp_rnd;
  logic [L2W-1:0]         ln_r;

  always_comb begin
    e_lz = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) e_lz = EW'(i);
    end
  end

  assign shl = {x1_r, {(MANT_W-1){1'b0}}} >> e1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= x;
      e1_r   <= e_lz;
      m_r[0] <= shl[MANT_W-1:0];
      f_r[0] <= '0;
      e_r[0] <= e1_r;
    end
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_sq
    logic [2*MANT_W-1:0] prod;
    logic [MANT_W:0]     sq;
    assign prod = m_r[j] * m_r[j];
    assign sq   = prod[2*MANT_W-1:MANT_W-1];
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[j+1] <= sq[MANT_W] ? sq[MANT_W:1] : sq[MANT_W-1:0];
        f_r[j+1] <= {f_r[j][FRAC_BITS-2:0], sq[MANT_W]};
        e_r[j+1] <= e_r[j];
      end
    end
  end

  assign lp_rnd = lp_r + (PW'(1) << 31);

  always_ff @(posedge clk) begin
    if (en) begin
      lp_r <= PW'({e_r[FRAC_BITS], f_r[FRAC_BITS]}) * PW'(LN2_Q32);
      ln_r <= lp_rnd[PW-1:32];
    end
  end

  assign ln_q = ln_r;

endmodule

@@ hdl/tatc_div.sv @@
// ----------------------------------------------------------------------------
// tatc_div
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must be below the divisor. Advances on en.
// ----------------------------------------------------------------------------
module tatc_div #(
  parameter int DW = 12,
  parameter int QW = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem0,
  input  logic [QW-1:0] lo,
  input  logic [DW-1:0] dvs,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_r [1:QW-1];
  logic [QW-1:0] lo_r  [1:QW-1];
  logic [DW-1:0] dvs_r [1:QW-1];
  logic [QW-1:0] q_r   [1:QW];

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [DW-1:0] rem_i;
    logic [DW-1:0] dvs_i;
    logic [QW-1:0] lo_i;
    logic [QW-1:0] q_i;
    logic [DW:0]   tr;
    logic [DW:0]   df;
    logic          ge;

    if (j == 0) begin : g_first
      assign rem_i = rem0;
      assign lo_i  = lo;
      assign dvs_i = dvs;
      assign q_i   = '0;
    end else begin : g_next
      assign rem_i = rem_r[j];
      assign lo_i  = lo_r[j];
      assign dvs_i = dvs_r[j];
      assign q_i   = q_r[j];
    end

    assign tr = {rem_i, lo_i[QW-1]};
    assign ge = tr >= {1'b0, dvs_i};
    assign df = tr - {1'b0, dvs_i};

    always_ff @(posedge clk) begin
      if (en) q_r[j+1] <= {q_i[QW-2:0], ge};
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1] <= ge ? df[DW-1:0] : tr[DW-1:0];
          lo_r[j+1]  <= lo_i << 1;
          dvs_r[j+1] <= dvs_i;
        end
      end
    end
  end

  assign quo = q_r[QW];

endmodule

@@ hdl/thermistor_adc_to_temperature_core.sv @@
// ----------------------------------------------------------------------------
// thermistor_adc_to_temperature_core
// NTC divider sample to resistance and temperature by the beta equation.
// ----------------------------------------------------------------------------
// Channels: in_ch carries one converter sample per item, out_ch one result
// item (resistance, kelvin/Celsius/Fahrenheit in hundredths, status), cfg_ch
// writes the five setup registers by index and is always ready.
// Throughput: one item per cycle while out_ch is not stalled. The depth is
// set by the log units (24 squaring stages each) feeding the 17-stage
// temperature divider; the resistance divider (33 stages) runs beside them.
// Stall: while a result waits on out_ch the whole pipeline holds and
// in_ch.ready is low; nothing is dropped or repeated.
// Reset: clears all valid bits and loads the register defaults.
// Setup registers may be written only while no item is in flight.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature_core import tatc_pkg::*; #(
  parameter int ADC_BITS = ADC_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tatc_in_if.sink    in_ch,
  tatc_out_if.source out_ch,
  tatc_cfg_if.sink   cfg_ch
);

  localparam logic [S_W-1:0] ADC_MASK = S_W'((64'd1 << ADC_BITS) - 64'd1);
  localparam int NUM_W  = SER_W + S_W;
  localparam int N2_W   = NUM_W + 1;
  localparam int LNN_W  = $clog2(NUM_W) + FRAC_BITS;
  localparam int LND_W  = $clog2(S_W) + FRAC_BITS;
  localparam int D_W    = 32;
  localparam int DV_W   = D_W - 1;
  localparam int BK_W   = BETA_W + 7;
  localparam int TN_W   = BK_W + FRAC_BITS + 1;
  localparam int CMP_W  = DV_W + K_W;
  localparam int FX_W   = 20;
  localparam int FP_W   = FX_W + 21;

  localparam int P_LN  = 1 + LN_LAT;
  localparam int P_D   = P_LN + 1;
  localparam int P_N   = P_D + 1;
  localparam int P_DV  = P_N + 1;
  localparam int P_Q   = P_DV + K_W;
  localparam int P_FIN = P_Q + 1;
  localparam int P_OUT = P_FIN + 1;
  localparam int P_RES = 1 + N2_W;

  logic                    en;
  logic [P_OUT:0]          vld_r;

  logic [S_W-1:0]          full_scale_r;
  logic [SER_W-1:0]        series_r;
  logic [BETA_W-1:0]       beta_r;
  logic signed [LRI_W-1:0] lri_r;
  logic                    low_side_r;

  logic [S_W-1:0]          s0_r;
  logic [S_W-1:0]          a0;
  logic [S_W-1:0]          diff0;
  logic [S_W-1:0]          opnd0;
  logic [S_W-1:0]          den0;
  logic [NUM_W-1:0]        num0;
  side_t                   side0;

  logic [NUM_W-1:0]        num1_r;
  logic [S_W-1:0]          den1_r;
  logic [N2_W-1:0]         n2_r;
  side_t                   side_r [1:P_Q];

  logic [LNN_W-1:0]        lnn;
  logic [LND_W-1:0]        lnd;
  logic signed [D_W-1:0]   d_nxt;
  logic                    dpos_nxt;
  logic [DV_W-1:0]         d30_r;
  logic [BK_W-1:0]         bk;
  logic [TN_W-1:0]         tn31_r;
  logic [DV_W-1:0]         d31_r;
  logic                    ovf_nxt;
  logic [DV_W-1:0]         rem0_r;
  logic [K_W-1:0]          lo_r;
  logic [DV_W-1:0]         dvs_r;
  logic [K_W-1:0]          tq;

  logic [N2_W-1:0]         res_q;
  logic [N2_W-1:0]         res_d_r [P_RES+1:P_Q];

  side_t                   sf;
  logic [N2_W-1:0]         rq;
  logic [RES_W-1:0]        fin_res_nxt;
  logic [K_W-1:0]          fin_k_nxt;
  status_t                 fin_st_nxt;
  logic [RES_W-1:0]        fin_res_r;
  logic [K_W-1:0]          fin_k_r;
  status_t                 fin_st_r;

  logic [FX_W-1:0]         fx;
  logic [FP_W-1:0]         fp;
  logic [RES_W-1:0]        out_res_r;
  logic [K_W-1:0]          out_k_r;
  logic signed [C_W-1:0]   out_c_r;
  logic signed [F_W-1:0]   out_f_r;
  status_t                 out_st_r;

  // pipeline advance
  assign en          = !vld_r[P_OUT] || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_scale_r <= FULL_SCALE_RST;
      series_r     <= SERIES_RST;
      beta_r       <= BETA_RST;
      lri_r        <= LRI_RST;
      low_side_r   <= LOW_SIDE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FULL_SCALE: full_scale_r <= cfg_ch.data[S_W-1:0];
        REG_SERIES:     series_r     <= cfg_ch.data[SER_W-1:0];
        REG_BETA:       beta_r       <= cfg_ch.data[BETA_W-1:0];
        REG_LOG_RINF:   lri_r        <= $signed(cfg_ch.data[LRI_W-1:0]);
        REG_LOW_SIDE:   low_side_r   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[P_OUT-1:0], in_ch.valid};
    end
  end

  // divider terms
  always_comb begin
    a0    = full_scale_r & ADC_MASK;
    diff0 = a0 - s0_r;
    opnd0 = low_side_r ? s0_r : diff0;
    den0  = low_side_r ? diff0 : s0_r;
    num0  = series_r * opnd0;
    side0 = '{short_f: (s0_r == '0), full_f: (s0_r >= a0),
              nzero_f: (series_r == '0), dpos_f: 1'b0, ovf_f: 1'b0};
  end

  // ln(num) - ln(den) - ln Roo
  assign d_nxt    = D_W'(lnn) - D_W'(lnd) - (D_W'(lri_r) <<< 8);
  assign dpos_nxt = !d_nxt[D_W-1] && (d_nxt != '0);
  assign bk       = beta_r * 7'd100;
  assign ovf_nxt  = CMP_W'(tn31_r) >= {d31_r, {K_W{1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r   <= in_ch.adc_sample & ADC_MASK;
      num1_r <= num0;
      den1_r <= den0;
      n2_r   <= N2_W'(num0) + N2_W'(den0 >> 1);
      side_r[1] <= side0;
      for (int i = 2; i <= P_Q; i++) begin
        if (i != P_D && i != P_DV) side_r[i] <= side_r[i-1];
      end
      side_r[P_D]  <= '{short_f: side_r[P_D-1].short_f, full_f: side_r[P_D-1].full_f,
                        nzero_f: side_r[P_D-1].nzero_f, dpos_f: dpos_nxt,
                        ovf_f: side_r[P_D-1].ovf_f};
      side_r[P_DV] <= '{short_f: side_r[P_DV-1].short_f, full_f: side_r[P_DV-1].full_f,
                        nzero_f: side_r[P_DV-1].nzero_f, dpos_f: side_r[P_DV-1].dpos_f,
                        ovf_f: ovf_nxt};
      d30_r  <= d_nxt[DV_W-1:0];
      tn31_r <= TN_W'({bk, {FRAC_BITS{1'b0}}}) + TN_W'(d30_r[DV_W-1:1]);
      d31_r  <= d30_r;
      rem0_r <= DV_W'(tn31_r[TN_W-1:K_W]);
      lo_r   <= tn31_r[K_W-1:0];
      dvs_r  <= d31_r;
      res_d_r[P_RES+1] <= res_q;
      for (int i = P_RES + 2; i <= P_Q; i++) res_d_r[i] <= res_d_r[i-1];
    end
  end

  tatc_ln #(.XW(NUM_W)) u_ln_num (
    .clk  (clk),
    .en   (en),
    .x    (num1_r),
    .ln_q (lnn)
  );

  tatc_ln #(.XW(S_W)) u_ln_den (
    .clk  (clk),
    .en   (en),
    .x    (den1_r),
    .ln_q (lnd)
  );

  tatc_div #(.DW(S_W), .QW(N2_W)) u_div_res (
    .clk  (clk),
    .en   (en),
    .rem0 ('0),
    .lo   (n2_r),
    .dvs  (den1_r),
    .quo  (res_q)
  );

  tatc_div #(.DW(DV_W), .QW(K_W)) u_div_temp (
    .clk  (clk),
    .en   (en),
    .rem0 (rem0_r),
    .lo   (lo_r),
    .dvs  (dvs_r),
    .quo  (tq)
  );

  // special cases and saturation
  always_comb begin
    sf          = side_r[P_Q];
    rq          = res_d_r[P_Q];
    fin_res_nxt = '0;
    fin_k_nxt   = '0;
    fin_st_nxt  = ST_OK;
    if (sf.short_f) begin
      fin_st_nxt = ST_SHORT;
      fin_k_nxt  = KELVIN_MAX;
    end else if (sf.full_f) begin
      fin_st_nxt  = ST_SAT;
      fin_res_nxt = low_side_r ? '1 : '0;
    end else if (sf.nzero_f) begin
      fin_st_nxt = ST_SAT;
    end else begin
      if (rq[N2_W-1]) begin
        fin_res_nxt = '1;
        fin_st_nxt  = ST_SAT;
      end else begin
        fin_res_nxt = rq[RES_W-1:0];
      end
      if (!sf.dpos_f || sf.ovf_f || (tq > KELVIN_MAX)) begin
        fin_k_nxt  = KELVIN_MAX;
        fin_st_nxt = ST_SAT;
      end else begin
        fin_k_nxt = tq;
      end
    end
  end

  // round(9K/5) by reciprocal multiply
  assign fx = FX_W'({fin_k_r, 3'b000}) + FX_W'(fin_k_r) + FX_W'(2);
  assign fp = FP_W'(fx) * FP_W'(DIV5_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      fin_res_r <= fin_res_nxt;
      fin_k_r   <= fin_k_nxt;
      fin_st_r  <= fin_st_nxt;
      out_res_r <= fin_res_r;
      out_k_r   <= fin_k_r;
      out_st_r  <= fin_st_r;
      out_c_r   <= C_W'({1'b0, fin_k_r}) - C_W'(ZERO_C_CENTI);
      out_f_r   <= F_W'({1'b0, fp[FP_W-1:DIV5_SH]}) - F_W'(ZERO_F_CENTI);
    end
  end

  assign out_ch.valid            = vld_r[P_OUT];
  assign out_ch.resistance_ohms  = out_res_r;
  assign out_ch.kelvin_centi     = out_k_r;
  assign out_ch.celsius_centi    = out_c_r;
  assign out_ch.fahrenheit_centi = out_f_r;
  assign out_ch.status           = out_st_r;

`ifndef SYNTHESIS
  a_short: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[P_OUT] && (out_st_r == ST_SHORT) |-> (out_k_r == KELVIN_MAX) && (out_res_r == '0))
    else $error("short item without saturated temperature");

  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[P_OUT] && (out_st_r == ST_OK) |-> (out_k_r <= KELVIN_MAX))
    else $error("normal item out of range");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[P_OUT] && !out_ch.ready |=> vld_r[P_OUT] && $stable(out_k_r) && $stable(out_res_r))
    else $error("pending item changed while stalled");
`endif

endmodule
